// ===== rtl/lift_gamma_gain_color_correct_unit_assert.svh =====
// Assertion macros used by the color correction checker.
`ifndef LIFT_GAMMA_GAIN_COLOR_CORRECT_UNIT_ASSERT_SVH
`define LIFT_GAMMA_GAIN_COLOR_CORRECT_UNIT_ASSERT_SVH
// Same-cycle implication, sampled on clk, off during reset.
`define LGGC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define LGGC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== rtl/lggc_pkg.sv =====
// Shared constants and elaboration-time functions for the color correction unit.
package lggc_pkg;

	localparam int COEF_W = 48;
	localparam logic [COEF_W-1:0] COEF_RESET = 48'h1000_0000_1000;
	localparam int CFG_IDX_W = 8;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_RED = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_GREEN = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_BLUE = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BYPASS = 8'd3;

	localparam int LOG_STEPS = 20;
	localparam int EXP_STEPS = 20;
	// Base (5) + normalize (1) + log steps + product (1) + split (1) + exp steps + scale (2).
	localparam int LANE_DEPTH = 50;
	localparam int PIPE_DEPTH = LANE_DEPTH + 1;

	// Floor square root of a 64-bit value, bit by bit.
	function automatic logic [63:0] isqrt64(input logic [63:0] x);
		logic [63:0] res;
		logic [63:0] bitv;
		logic [63:0] rem;
		res = '0;
		bitv = 64'd1 << 62;
		rem = x;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + bitv) begin
				rem = rem - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	// Q30 value of 2^(2^-k), built by repeated floor square roots.
	function automatic logic [63:0] exp_root(input int k);
		logic [63:0] r;
		r = '0;
		for (int i = 1; i <= EXP_STEPS; i++) begin
			if (i <= k) begin
				r = isqrt64((i == 1) ? (64'd2 << 60) : (r << 30));
			end
		end
		return r;
	endfunction

endpackage

// ===== rtl/lggc_lane.sv =====
// One color channel: base, log2, exponent product, exp2 and output scaling.
module lggc_lane #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                          clk,
	input  logic [lggc_pkg::LANE_DEPTH-1:0] en,
	input  logic [CHANNEL_BITS-1:0]       chan,
	input  logic [lggc_pkg::COEF_W-1:0]   coef,
	output logic [CHANNEL_BITS-1:0]       res
);

	localparam int CB = CHANNEL_BITS;
	localparam logic [CB-1:0] MAXV = '1;
	localparam logic [CB-1:0] HALF = MAXV >> 1;
	localparam int PW = CB + 16;
	localparam int Y2W = CB + 13;
	localparam logic [16:0] R1 = 17'((64'd1 << PW) / 64'(MAXV));
	localparam logic [13:0] R2 = 14'((64'd1 << Y2W) / 64'(MAXV));
	localparam int LS = lggc_pkg::LOG_STEPS;
	localparam int ES = lggc_pkg::EXP_STEPS;

	logic [15:0] gain;
	logic signed [15:0] lift;
	logic [15:0] ex;

	assign gain = coef[15:0];
	assign lift = coef[31:16];
	assign ex = coef[47:32];

	// Stage 1: channel times gain.
	logic [PW-1:0] p_s1;
	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_s1 <= PW'(chan) * PW'(gain);
		end
	end

	// Stage 2: reciprocal estimate of the division by full scale.
	logic [PW+16:0] pr_s2;
	logic [PW-1:0] p_s2;
	always_ff @(posedge clk) begin
		if (en[1]) begin
			pr_s2 <= (PW+17)'(p_s1) * (PW+17)'(R1);
			p_s2 <= p_s1;
		end
	end

	// Stage 3: correct the quotient, then form the rounded remainder term.
	logic [16:0] qe3;
	logic [CB+16:0] qm3;
	logic [PW-1:0] rem3;
	logic ge3;
	logic [CB-1:0] rc3;
	logic [16:0] qp_s3;
	logic [Y2W-1:0] y2_s3;
	always_comb begin
		qe3 = pr_s2[PW+16:PW];
		qm3 = {qe3, {CB{1'b0}}} - (CB+17)'(qe3);
		rem3 = p_s2 - qm3[PW-1:0];
		ge3 = rem3 >= PW'(MAXV);
		rc3 = ge3 ? CB'(rem3 - PW'(MAXV)) : CB'(rem3);
	end
	always_ff @(posedge clk) begin
		if (en[2]) begin
			qp_s3 <= qe3 + 17'(ge3);
			y2_s3 <= Y2W'({rc3, 12'd0}) + Y2W'(HALF);
		end
	end

	// Stage 4: reciprocal estimate for the fraction part.
	logic [Y2W+13:0] pr_s4;
	logic [Y2W-1:0] y2_s4;
	logic [16:0] qp_s4;
	always_ff @(posedge clk) begin
		if (en[3]) begin
			pr_s4 <= (Y2W+14)'(y2_s3) * (Y2W+14)'(R2);
			y2_s4 <= y2_s3;
			qp_s4 <= qp_s3;
		end
	end

	// Stage 5: correct, then assemble the Q24 base with lift.
	logic [13:0] qe5;
	logic [CB+13:0] qm5;
	logic [Y2W-1:0] r5;
	logic [13:0] q5;
	logic signed [29:0] b_s5;
	always_comb begin
		qe5 = pr_s4[Y2W+13:Y2W];
		qm5 = {qe5, {CB{1'b0}}} - (CB+14)'(qe5);
		r5 = y2_s4 - qm5[Y2W-1:0];
		q5 = qe5 + 14'(r5 >= Y2W'(MAXV));
	end
	always_ff @(posedge clk) begin
		if (en[4]) begin
			b_s5 <= $signed({1'b0, qp_s4, 12'd0}) + $signed({16'd0, q5})
				+ $signed({{3{lift[15]}}, lift, 11'd0});
		end
	end

	// Stage 6: leading one and mantissa normalization to Q30.
	logic [4:0] lo6;
	logic [LS:0][30:0] lm;
	logic [LS:0][19:0] lf;
	logic [LS:0][4:0] lp;
	logic [LS:0] lz;
	always_comb begin
		lo6 = '0;
		for (int i = 0; i < 29; i++) begin
			if (b_s5[i]) begin
				lo6 = 5'(i);
			end
		end
	end
	always_ff @(posedge clk) begin
		if (en[5]) begin
			lm[0] <= {2'b00, b_s5[28:0]} << (5'd30 - lo6);
			lf[0] <= '0;
			lp[0] <= lo6;
			lz[0] <= b_s5[29] || (b_s5 == '0);
		end
	end

	// Log2 fraction: one squaring of the mantissa per stage.
	for (genvar k = 1; k <= LS; k++) begin : g_log
		logic [61:0] sq;
		logic [31:0] t;
		assign sq = 62'(lm[k-1]) * 62'(lm[k-1]);
		assign t = sq[61:30];
		always_ff @(posedge clk) begin
			if (en[5+k]) begin
				lm[k] <= t[31] ? t[31:1] : t[30:0];
				lf[k] <= {lf[k-1][18:0], t[31]};
				lp[k] <= lp[k-1];
				lz[k] <= lz[k-1];
			end
		end
	end

	// Stage 27: log2 times exponent, floored back to Q20.
	logic [5:0] pm24;
	logic signed [42:0] prod27;
	logic signed [30:0] y_s27;
	logic z_s27;
	always_comb begin
		pm24 = {1'b0, lp[LS]} - 6'd24;
		prod27 = $signed({pm24, lf[LS]}) * $signed({1'b0, ex});
	end
	always_ff @(posedge clk) begin
		if (en[26]) begin
			y_s27 <= prod27[42:12];
			z_s27 <= lz[LS];
		end
	end

	// Stage 28: split into integer shift and fraction.
	logic [10:0] qv28;
	logic [ES:0][30:0] ea;
	logic [ES:0][19:0] ef;
	logic [ES:0][5:0] eq;
	logic [ES:0] ek;
	logic [ES:0] efull;
	logic [ES:0] ez;
	assign qv28 = 11'd0 - y_s27[30:20];
	always_ff @(posedge clk) begin
		if (en[27]) begin
			ea[0] <= 31'd1 << 30;
			ef[0] <= y_s27[19:0];
			eq[0] <= qv28[5:0];
			ek[0] <= |qv28[10:6];
			efull[0] <= !y_s27[30];
			ez[0] <= z_s27;
		end
	end

	// Exp2 of the fraction: one conditional root product per stage.
	for (genvar k = 1; k <= ES; k++) begin : g_exp
		localparam logic [63:0] ROOT = lggc_pkg::exp_root(k);
		logic [61:0] pe;
		assign pe = 62'(ea[k-1]) * 62'(ROOT[30:0]);
		always_ff @(posedge clk) begin
			if (en[27+k]) begin
				ea[k] <= ef[k-1][ES-k] ? pe[60:30] : ea[k-1];
				ef[k] <= ef[k-1];
				eq[k] <= eq[k-1];
				ek[k] <= ek[k-1];
				efull[k] <= efull[k-1];
				ez[k] <= ez[k-1];
			end
		end
	end

	// Stage 49: scale by full scale.
	logic [CB+30:0] mv_s49;
	logic [5:0] q_s49;
	logic k_s49;
	logic full_s49;
	logic z_s49;
	always_ff @(posedge clk) begin
		if (en[48]) begin
			mv_s49 <= (CB+31)'(MAXV) * (CB+31)'(ea[ES]);
			q_s49 <= eq[ES];
			k_s49 <= ek[ES];
			full_s49 <= efull[ES];
			z_s49 <= ez[ES];
		end
	end

	// Stage 50: integer shift, bias, truncate and saturate.
	logic [CB+31:0] val50;
	logic [CB+1:0] v50;
	logic [CB-1:0] res_s50;
	always_comb begin
		val50 = (CB+32)'(mv_s49 >> q_s49) + (CB+32)'(32'd1 << 24);
		v50 = val50[CB+31:30];
	end
	always_ff @(posedge clk) begin
		if (en[49]) begin
			if (z_s49 || (!full_s49 && k_s49)) begin
				res_s50 <= '0;
			end else if (full_s49 || (v50 > (CB+2)'(MAXV))) begin
				res_s50 <= MAXV;
			end else begin
				res_s50 <= v50[CB-1:0];
			end
		end
	end

	assign res = res_s50;

endmodule

// ===== rtl/lift_gamma_gain_color_correct_unit.sv =====
// An accepted request passes 50 lane stages and an output register before out_valid.
// One pixel per clock when not stalled; stages hold until the next frees, so bubbles collapse.
// The log2 and exp2 step chains, one multiply per stage, set the depth of each color lane.
// Reset clears all stage valid bits and loads identity coefficients with bypass off.
// Configuration is taken every cycle (cfg_ready is always high).
module lift_gamma_gain_color_correct_unit #(
	parameter int CHANNEL_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [CHANNEL_BITS-1:0]        red_in,
	input  logic [CHANNEL_BITS-1:0]        green_in,
	input  logic [CHANNEL_BITS-1:0]        blue_in,
	input  logic [CHANNEL_BITS-1:0]        alpha_in,
	input  logic                           end_of_frame,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [CHANNEL_BITS-1:0]        red_out,
	output logic [CHANNEL_BITS-1:0]        green_out,
	output logic [CHANNEL_BITS-1:0]        blue_out,
	output logic [CHANNEL_BITS-1:0]        alpha_out,
	output logic                           frame_last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [lggc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lggc_pkg::COEF_W-1:0]    cfg_data
);

	localparam int CB = CHANNEL_BITS;
	localparam int LD = lggc_pkg::LANE_DEPTH;
	localparam int PD = lggc_pkg::PIPE_DEPTH;

	typedef struct packed {
		logic [CB-1:0] red;
		logic [CB-1:0] green;
		logic [CB-1:0] blue;
		logic [CB-1:0] alpha;
		logic eof;
	} side_t;

	logic [2:0][lggc_pkg::COEF_W-1:0] coef_q;
	logic bypass_q;
	logic [PD-1:0] v_q;
	logic [PD-1:0] en;
	side_t side_q [0:LD-1];
	logic [CB-1:0] res_r, res_g, res_b;
	side_t out_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= {3{lggc_pkg::COEF_RESET}};
			bypass_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lggc_pkg::CFG_COEF_RED: coef_q[0] <= cfg_data;
				lggc_pkg::CFG_COEF_GREEN: coef_q[1] <= cfg_data;
				lggc_pkg::CFG_COEF_BLUE: coef_q[2] <= cfg_data;
				lggc_pkg::CFG_BYPASS: bypass_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// A stage loads when it is empty or its successor loads.
	always_comb begin
		en[PD-1] = !v_q[PD-1] || !out_stall;
		for (int i = PD - 2; i >= 0; i--) begin
			en[i] = !v_q[i] || en[i+1];
		end
	end
	assign in_stall = !en[0];

	// Stage valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int i = 1; i < PD; i++) begin
				if (en[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	// Pass-through fields and raw colors travel beside the lanes.
	always_ff @(posedge clk) begin
		if (en[0]) begin
			side_q[0] <= '{red: red_in, green: green_in, blue: blue_in,
				alpha: alpha_in, eof: end_of_frame};
		end
		for (int i = 1; i < LD; i++) begin
			if (en[i]) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	// One lane per color channel.
	lggc_lane #(.CHANNEL_BITS(CB)) u_lane_r (
		.clk(clk), .en(en[LD-1:0]), .chan(red_in), .coef(coef_q[0]), .res(res_r)
	);
	lggc_lane #(.CHANNEL_BITS(CB)) u_lane_g (
		.clk(clk), .en(en[LD-1:0]), .chan(green_in), .coef(coef_q[1]), .res(res_g)
	);
	lggc_lane #(.CHANNEL_BITS(CB)) u_lane_b (
		.clk(clk), .en(en[LD-1:0]), .chan(blue_in), .coef(coef_q[2]), .res(res_b)
	);

	// Merge the lane results with the pass-through fields.
	always_ff @(posedge clk) begin
		if (en[PD-1]) begin
			out_q.red <= bypass_q ? side_q[LD-1].red : res_r;
			out_q.green <= bypass_q ? side_q[LD-1].green : res_g;
			out_q.blue <= bypass_q ? side_q[LD-1].blue : res_b;
			out_q.alpha <= side_q[LD-1].alpha;
			out_q.eof <= side_q[LD-1].eof;
		end
	end

	assign out_valid = v_q[PD-1];
	assign red_out = out_q.red;
	assign green_out = out_q.green;
	assign blue_out = out_q.blue;
	assign alpha_out = out_q.alpha;
	assign frame_last = out_q.eof;

endmodule

// ===== rtl/lggc_checker.sv =====
// Port-level checker for the color correction unit, bound to the top level.
`include "lift_gamma_gain_color_correct_unit_assert.svh"
module lggc_checker #(
	parameter int CHANNEL_BITS = 8
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [CHANNEL_BITS-1:0]        red_out,
	input logic [CHANNEL_BITS-1:0]        green_out,
	input logic [CHANNEL_BITS-1:0]        blue_out,
	input logic [CHANNEL_BITS-1:0]        alpha_out,
	input logic                           frame_last,
	input logic                           cfg_valid,
	input logic                           cfg_ready
);

	// A stalled result stays offered.
	`LGGC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped under stall")
	// A stalled result keeps its payload.
	`LGGC_ASSERT_NXT(a_out_stable, out_valid && out_stall,
		$stable(red_out) && $stable(green_out) && $stable(blue_out)
		&& $stable(alpha_out) && $stable(frame_last), "payload changed under stall")
	// The input is held off only when a stalled result blocks a full pipeline.
	`LGGC_ASSERT_IMP(a_stall_cause, in_stall, out_valid && out_stall,
		"input stalled without output backpressure")
	// Register writes are always taken.
	`LGGC_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "configuration write refused")

endmodule

bind lift_gamma_gain_color_correct_unit lggc_checker #(.CHANNEL_BITS(CHANNEL_BITS)) u_lggc_checker (.*);

// ===== bench/lift_gamma_gain_color_correct_unit_tb.sv =====
// Self-checking testbench for the lift/gamma/gain color correction unit.
`timescale 1ns / 100ps

module lift_gamma_gain_color_correct_unit_tb;

	localparam int CB = 8;
	localparam int IW = lggc_pkg::CFG_IDX_W;
	localparam int CW = lggc_pkg::COEF_W;
	localparam longint unsigned MAXV = (1 << CB) - 1;
	localparam int LATENCY = 51;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [CB-1:0] red;
		logic [CB-1:0] green;
		logic [CB-1:0] blue;
		logic [CB-1:0] alpha;
		logic          eof;
	} pixel_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [CB-1:0] red_in, green_in, blue_in, alpha_in;
	logic end_of_frame;
	logic out_valid;
	logic out_stall;
	logic [CB-1:0] red_out, green_out, blue_out, alpha_out;
	logic frame_last;
	logic cfg_valid;
	logic cfg_ready;
	logic [IW-1:0] cfg_index;
	logic [CW-1:0] cfg_data;

	lift_gamma_gain_color_correct_unit #(.CHANNEL_BITS(CB)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.red_in(red_in), .green_in(green_in), .blue_in(blue_in),
		.alpha_in(alpha_in), .end_of_frame(end_of_frame),
		.out_valid(out_valid), .out_stall(out_stall),
		.red_out(red_out), .green_out(green_out), .blue_out(blue_out),
		.alpha_out(alpha_out), .frame_last(frame_last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Predictor copy of the register file.
	logic [CW-1:0] coef_model [3];
	logic bypass_model;

	pixel_t pending_pixels [$];
	pixel_t expected_pixels [$];
	int errors = 0;
	int watchdog = 0;
	bit hold_off = 0;
	bit stimulus_done = 0;

	// Powers 2^(2^-k) in Q30, floor square roots chained from the square root of two.
	longint unsigned root_tab [1:20];

	function automatic longint unsigned floor_sqrt(input longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// Log2 of a positive Q24 value, in Q20.
	function automatic longint log2_fixed(input longint unsigned b);
		int p;
		longint unsigned m;
		longint frac;
		p = 63;
		frac = 0;
		while (p > 0 && b[p] == 1'b0) p--;
		m = (p <= 30) ? (b << (30 - p)) : (b >> (p - 30));
		for (int i = 0; i < 20; i++) begin
			m = (m * m) >> 30;
			frac <<= 1;
			if (m >= (64'd2 << 30)) begin
				frac |= 1;
				m >>= 1;
			end
		end
		return (longint'(p) - 24) * 1048576 + frac;
	endfunction

	// Corrected value of one color channel.
	function automatic logic [CB-1:0] grade_channel(input logic [CB-1:0] c,
			input logic [CW-1:0] coef);
		longint unsigned gain, ex, q, acc, val;
		longint lift, b, l, prod, y, n, f;
		gain = coef[15:0];
		lift = longint'($signed(coef[31:16]));
		ex = coef[47:32];
		b = longint'((longint'(c) * gain * 4096 + MAXV / 2) / MAXV) + lift * 2048;
		if (b <= 0) return '0;
		l = log2_fixed(b);
		prod = l * longint'(ex);
		if (prod >= 0) y = prod / 4096;
		else y = -((-prod + 4095) / 4096);
		if (y >= 0) return MAXV[CB-1:0];
		n = -y;
		q = (n + 1048575) / 1048576;
		f = longint'(q) * 1048576 - n;
		acc = 64'd1 << 30;
		for (int k = 1; k <= 20; k++)
			if (f[20-k]) acc = (acc * root_tab[k]) >> 30;
		if (q > 63) return '0;
		val = (((MAXV * acc) >> q) + (64'd1 << 24)) >> 30;
		return (val > MAXV) ? MAXV[CB-1:0] : val[CB-1:0];
	endfunction

	function automatic pixel_t grade_pixel(input pixel_t px);
		pixel_t r;
		r = px;
		if (!bypass_model) begin
			r.red = grade_channel(px.red, coef_model[0]);
			r.green = grade_channel(px.green, coef_model[1]);
			r.blue = grade_channel(px.blue, coef_model[2]);
		end
		return r;
	endfunction

	function automatic logic [CW-1:0] pack_coef(input logic [15:0] gain,
			input logic [15:0] lift, input logic [15:0] ex);
		return {ex, lift, gain};
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		px.red = 8'($urandom);
		px.green = 8'($urandom);
		px.blue = 8'($urandom);
		px.alpha = 8'($urandom);
		px.eof = ($urandom_range(0, 15) == 0);
		return px;
	endfunction

	// Clock.
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Register write; ready is sampled at the edge.
	task automatic write_reg(input logic [IW-1:0] idx, input logic [CW-1:0] value);
		cfg_index <= idx;
		cfg_data <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == lggc_pkg::CFG_COEF_RED) coef_model[0] = value;
		else if (idx == lggc_pkg::CFG_COEF_GREEN) coef_model[1] = value;
		else if (idx == lggc_pkg::CFG_COEF_BLUE) coef_model[2] = value;
		else if (idx == lggc_pkg::CFG_BYPASS) bypass_model = value[0];
	endtask

	// Wait until the pipeline has drained.
	task automatic drain();
		while (pending_pixels.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_all(input logic [CW-1:0] r, input logic [CW-1:0] g,
			input logic [CW-1:0] b, input logic byp);
		write_reg(lggc_pkg::CFG_COEF_RED, r);
		write_reg(lggc_pkg::CFG_COEF_GREEN, g);
		write_reg(lggc_pkg::CFG_COEF_BLUE, b);
		write_reg(lggc_pkg::CFG_BYPASS, {47'd0, byp});
	endtask

	function automatic logic [CW-1:0] random_coef();
		// Mostly mild corrections, sometimes any bit pattern.
		if ($urandom_range(0, 3) == 0)
			return 48'({$urandom, $urandom});
		return pack_coef(16'($urandom_range(0, 16'h2000)),
			16'(int'($urandom_range(0, 4096)) - 2048),
			16'($urandom_range(0, 16'h3000)));
	endfunction

	task automatic queue_random(input int count);
		for (int i = 0; i < count; i++) pending_pixels.push_back(random_pixel());
	endtask

	// Stimulus phases.
	initial begin
		logic [CW-1:0] extremes [6];
		root_tab[1] = floor_sqrt(64'd2 << 60);
		for (int k = 2; k <= 20; k++) root_tab[k] = floor_sqrt(root_tab[k-1] << 30);
		coef_model[0] = lggc_pkg::COEF_RESET;
		coef_model[1] = lggc_pkg::COEF_RESET;
		coef_model[2] = lggc_pkg::COEF_RESET;
		bypass_model = 1'b0;
		cfg_valid = 0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Identity setting, extreme pixel values.
		pending_pixels.push_back(pixel_t'{8'h00, 8'h00, 8'h00, 8'h00, 1'b0});
		pending_pixels.push_back(pixel_t'{8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1});
		pending_pixels.push_back(pixel_t'{8'h01, 8'h80, 8'hFE, 8'h55, 1'b0});
		drain();

		// Directed corner cases: zero exponent, negative base, base above one, darkening gamma.
		set_all(pack_coef(16'h1000, 16'h0000, 16'h0000),
			pack_coef(16'h1000, 16'hC000, 16'h1000),
			pack_coef(16'hFFFF, 16'h7FFF, 16'hFFFF), 1'b0);
		for (int v = 0; v < 4; v++)
			pending_pixels.push_back(pixel_t'{8'(v * 85), 8'(255 - v * 85), 8'(v * 60),
				8'(v), 1'(v & 1)});
		drain();
		set_all(pack_coef(16'h0800, 16'h0400, 16'h2000),
			pack_coef(16'h0000, 16'h8000, 16'hFFFF),
			pack_coef(16'h1000, 16'hFC00, 16'h0001), 1'b0);
		pending_pixels.push_back(pixel_t'{8'h00, 8'hFF, 8'h01, 8'hAA, 1'b0});
		pending_pixels.push_back(pixel_t'{8'hFF, 8'h00, 8'hFF, 8'h33, 1'b1});
		pending_pixels.push_back(pixel_t'{8'h10, 8'h7F, 8'hC0, 8'hF0, 1'b0});
		drain();

		// Bypass passes the pixel unchanged.
		write_reg(lggc_pkg::CFG_BYPASS, 48'd1);
		pending_pixels.push_back(pixel_t'{8'hFF, 8'h00, 8'h5A, 8'hA5, 1'b1});
		pending_pixels.push_back(pixel_t'{8'h00, 8'hFF, 8'hA5, 8'h5A, 1'b0});
		drain();

		// Out of range index must be ignored.
		write_reg(IW'(4), 48'hFFFF_FFFF_FFFF);
		write_reg(lggc_pkg::CFG_BYPASS, 48'hFFFF_FFFF_FFFE);
		queue_random(4);
		drain();

		// Random phases, with one long hold-off at the receiver in the first.
		extremes = '{48'h0, 48'hFFFF_FFFF_FFFF, lggc_pkg::COEF_RESET,
			pack_coef(16'h1000, 16'h0000, 16'hFFFF), pack_coef(16'hFFFF, 16'h8000, 16'h0001),
			pack_coef(16'h0001, 16'h7FFF, 16'h1000)};
		for (int ph = 0; ph < 10; ph++) begin
			if (ph < 3)
				set_all(extremes[$urandom_range(0, 5)], extremes[$urandom_range(0, 5)],
					extremes[$urandom_range(0, 5)], 1'b0);
			else
				set_all(random_coef(), random_coef(), random_coef(), ph == 9);
			if (ph == 0) hold_off = 1;
			queue_random(130);
			drain();
		end
		stimulus_done = 1;
	end

	// Sender: bursts of random length with gaps between them.
	int burst_left = 0;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			red_in <= '0;
			green_in <= '0;
			blue_in <= '0;
			alpha_in <= '0;
			end_of_frame <= 0;
		end else if (in_valid && in_stall) begin
			// Hold the offered pixel.
		end else begin
			if (in_valid) begin
				expected_pixels.push_back(grade_pixel(pending_pixels.pop_front()));
				burst_left--;
			end
			if (burst_left <= 0 && gap_left <= 0) begin
				burst_left = $urandom_range(1, 40);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end
			if (gap_left > 0 && burst_left > 0 && !in_valid) gap_left--;
			if (gap_left == 0 && pending_pixels.size() != 0) begin
				in_valid <= 1;
				red_in <= pending_pixels[0].red;
				green_in <= pending_pixels[0].green;
				blue_in <= pending_pixels[0].blue;
				alpha_in <= pending_pixels[0].alpha;
				end_of_frame <= pending_pixels[0].eof;
			end else begin
				in_valid <= 0;
				if (burst_left <= 0) gap_left--;
			end
		end
	end

	// Receiver: stall pattern of its own, plus one long hold-off.
	int stall_cnt = 0;
	int hold_cnt = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 0;
		end else if (hold_off && hold_cnt < 300) begin
			hold_cnt <= hold_cnt + 1;
			out_stall <= 1;
		end else begin
			stall_cnt <= stall_cnt + 1;
			if (stall_cnt[8]) out_stall <= 0;
			else out_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	// Monitor and checker.
	always @(posedge clk) begin
		pixel_t exp_px;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_pixels.size() == 0) begin
				$error("unexpected pixel at output");
				errors++;
			end else begin
				exp_px = expected_pixels.pop_front();
				if (red_out !== exp_px.red) begin
					$error("red_out expected %0d got %0d", exp_px.red, red_out);
					errors++;
				end
				if (green_out !== exp_px.green) begin
					$error("green_out expected %0d got %0d", exp_px.green, green_out);
					errors++;
				end
				if (blue_out !== exp_px.blue) begin
					$error("blue_out expected %0d got %0d", exp_px.blue, blue_out);
					errors++;
				end
				if (alpha_out !== exp_px.alpha) begin
					$error("alpha_out expected %0d got %0d", exp_px.alpha, alpha_out);
					errors++;
				end
				if (frame_last !== exp_px.eof) begin
					$error("frame_last expected %0d got %0d", exp_px.eof, frame_last);
					errors++;
				end
			end
		end
	end

	// Watchdog on cycles with no accepted input, accepted output or configuration write, and the end of the run.
	always @(posedge clk) begin
		if (stimulus_done) begin
			if (errors == 0 && expected_pixels.size() == 0) $display("SCOREBOARD CLEAN");
			else $display("SCOREBOARD MISMATCH");
			$finish;
		end else if (watchdog >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_valid) begin
			watchdog <= 0;
		end else begin
			watchdog <= watchdog + 1;
		end
	end

endmodule
